@@ design/cma_pkg.sv @@
// ----------------------------------------------------------------------------
// cma_pkg
// shared widths, types and constants of the centered moving average
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cma_pkg;

    // window geometry
    localparam int MAX_HALF_WIDTH = 10;
    localparam int HIST_DEPTH     = 2 * MAX_HALF_WIDTH + 1;

    // fixed field widths
    localparam int SAMPLE_W = 24;
    localparam int CFG_W    = 4;

    // derived widths
    localparam int HW_W  = $clog2(MAX_HALF_WIDTH + 1);
    localparam int TOP_W = $clog2(HIST_DEPTH);
    localparam int CNT_W = $clog2(HIST_DEPTH + 1);
    localparam int DIV_W = CNT_W;
    localparam int MAG_W = SAMPLE_W - 1 + $clog2(HIST_DEPTH);
    localparam int SUM_W = MAG_W + 1;
    localparam int RCP_W = MAG_W + 1;
    localparam int QD_W  = SAMPLE_W + DIV_W;

    // command queue between front and back
    localparam int CMD_FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W     = $clog2(CMD_FIFO_DEPTH);
    localparam int FIFO_CNT_W     = $clog2(CMD_FIFO_DEPTH + 1);

    localparam logic [HW_W-1:0] HALF_WIDTH_RESET = HW_W'(1);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [SUM_W-1:0]    sum_t;

    // one division job: window sum, number of samples, end-of-record mark
    typedef struct packed {
        sum_t               sum;
        logic [DIV_W-1:0]   divisor;
        logic               last;
    } cmd_t;

endpackage

`default_nettype wire

@@ design/cma_if.sv @@
// ----------------------------------------------------------------------------
// cma channel interfaces
// valid/ready channels for samples, results and the half width register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cma_sample_if import cma_pkg::*;;
    logic    valid;
    logic    ready;
    sample_t sample;
    logic    last_in;

    modport source (output valid, output sample, output last_in, input ready);
    modport sink   (input valid, input sample, input last_in, output ready);
endinterface

interface cma_result_if import cma_pkg::*;;
    logic    valid;
    logic    ready;
    sample_t average;
    logic    last_out;

    modport source (output valid, output average, output last_out, input ready);
    modport sink   (input valid, input average, input last_out, output ready);
endinterface

interface cma_cfg_if import cma_pkg::*;;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] half_width;

    modport source (output valid, output half_width, input ready);
    modport sink   (input valid, input half_width, output ready);
endinterface

`default_nettype wire

@@ design/cma_front.sv @@
// ----------------------------------------------------------------------------
// cma_front
// sample history, running window sum and end-of-record tail sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cma_front import cma_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    cma_sample_if.sink     smp,
    cma_cfg_if.sink        cfg,
    input  logic           fifo_full,
    output logic           push_valid,
    output cmd_t           push_cmd
);

    typedef enum logic {ST_IDLE, ST_TAIL} state_t;

    state_t            state_reg, state_next;
    logic [HW_W-1:0]   half_reg, half_next;
    logic [CNT_W-1:0]  seen_reg, seen_next;
    sum_t              sum_reg, sum_next;
    logic [TOP_W-1:0]  top_reg, top_next;
    logic [HW_W-1:0]   pend_reg, pend_next;
    sample_t           hist_reg [HIST_DEPTH];

    logic              accept;
    logic [TOP_W-1:0]  two_h;
    logic [TOP_W-1:0]  rd_idx;
    sample_t           hist_rd;
    sum_t              hist_ext;
    sum_t              smp_ext;
    logic [CNT_W-1:0]  seen_inc;
    logic              drop;
    logic              emit;
    logic              shrink;
    sum_t              base;
    sum_t              sum_acc;
    sum_t              sum_tail;
    logic [TOP_W-1:0]  top_acc;
    logic [TOP_W-1:0]  top_tail;
    logic [TOP_W-1:0]  pend_sum;
    logic [HW_W-1:0]   pend_dec;
    logic [HW_W-1:0]   pend_first;
    logic [HW_W-1:0]   cfg_half;

    assign two_h     = TOP_W'({half_reg, 1'b0});
    assign smp.ready = (state_reg == ST_IDLE) && !fifo_full;
    assign cfg.ready = 1'b1;
    assign accept    = smp.valid && smp.ready;

    // single read port: oldest sample of the window, or current tail top
    assign rd_idx   = (state_reg == ST_TAIL) ? top_reg : two_h;
    assign hist_rd  = hist_reg[rd_idx];
    assign hist_ext = {{(SUM_W - SAMPLE_W){hist_rd[SAMPLE_W-1]}}, hist_rd};
    assign smp_ext  = {{(SUM_W - SAMPLE_W){smp.sample[SAMPLE_W-1]}}, smp.sample};

    always_comb
    begin
        seen_inc   = (seen_reg < CNT_W'(HIST_DEPTH)) ? seen_reg + CNT_W'(1) : seen_reg;
        drop       = seen_reg > CNT_W'(two_h);
        base       = (seen_reg == '0) ? '0 : sum_reg;
        sum_acc    = base + smp_ext - (drop ? hist_ext : '0);
        top_acc    = drop ? two_h : TOP_W'(seen_reg);
        emit       = seen_inc > CNT_W'(half_reg);
        pend_first = (seen_inc < CNT_W'(half_reg)) ? HW_W'(seen_inc) : half_reg;

        // tail: window top shrinks by one whenever pend - 1 + h falls below it
        pend_dec   = pend_reg - HW_W'(1);
        pend_sum   = TOP_W'(pend_dec) + TOP_W'(half_reg);
        shrink     = pend_sum < top_reg;
        sum_tail   = shrink ? sum_reg - hist_ext : sum_reg;
        top_tail   = shrink ? top_reg - TOP_W'(1) : top_reg;

        // out-of-range half widths clamp to 1 .. MAX_HALF_WIDTH
        if (cfg.half_width == '0)
        begin
            cfg_half = HW_W'(1);
        end
        else if (int'(cfg.half_width) > MAX_HALF_WIDTH)
        begin
            cfg_half = HW_W'(MAX_HALF_WIDTH);
        end
        else
        begin
            cfg_half = HW_W'(cfg.half_width);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        half_next  = half_reg;
        seen_next  = seen_reg;
        sum_next   = sum_reg;
        top_next   = top_reg;
        pend_next  = pend_reg;
        push_valid = 1'b0;
        push_cmd.sum     = sum_acc;
        push_cmd.divisor = DIV_W'(top_acc) + DIV_W'(1);
        push_cmd.last    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    sum_next   = sum_acc;
                    top_next   = top_acc;
                    push_valid = emit;
                    if (smp.last_in)
                    begin
                        seen_next  = '0;
                        pend_next  = pend_first;
                        state_next = ST_TAIL;
                    end
                    else
                    begin
                        seen_next = seen_inc;
                    end
                end
            end
            ST_TAIL:
            begin
                push_cmd.sum     = sum_tail;
                push_cmd.divisor = DIV_W'(top_tail) + DIV_W'(1);
                push_cmd.last    = (pend_dec == '0);
                if (!fifo_full)
                begin
                    push_valid = 1'b1;
                    sum_next   = sum_tail;
                    top_next   = top_tail;
                    pend_next  = pend_dec;
                    if (pend_dec == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a register write abandons the record in progress
        if (cfg.valid && cfg.ready)
        begin
            half_next  = cfg_half;
            seen_next  = '0;
            state_next = ST_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            half_reg  <= HALF_WIDTH_RESET;
            seen_reg  <= '0;
            sum_reg   <= '0;
            top_reg   <= '0;
            pend_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            half_reg  <= half_next;
            seen_reg  <= seen_next;
            sum_reg   <= sum_next;
            top_reg   <= top_next;
            pend_reg  <= pend_next;
        end
    end

    // history shift line, newest at index 0
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hist_reg[0] <= smp.sample;
            for (int k = 1; k < HIST_DEPTH; k++)
            begin
                hist_reg[k] <= hist_reg[k-1];
            end
        end
    end

endmodule

`default_nettype wire

@@ design/cma_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// cma_cmd_fifo
// short command queue decoupling the front from the divider pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cma_cmd_fifo import cma_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    input  cmd_t  push_cmd,
    output logic  full,
    output logic  pop_valid,
    output cmd_t  pop_cmd,
    input  logic  pop
);

    cmd_t                   fifo_reg [CMD_FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == FIFO_CNT_W'(CMD_FIFO_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_valid)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(CMD_FIFO_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + FIFO_PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(CMD_FIFO_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + FIFO_PTR_W'(1);
        end
        if (push_valid && !pop)
        begin
            count_next = count_reg + FIFO_CNT_W'(1);
        end
        else if (pop && !push_valid)
        begin
            count_next = count_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            fifo_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

@@ design/cma_back.sv @@
// ----------------------------------------------------------------------------
// cma_back
// divider pipeline: reciprocal multiply, one-step correction, sign restore
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cma_back import cma_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cmd_valid,
    input  cmd_t         cmd,
    output logic         cmd_pop,
    cma_result_if.source res
);

    localparam int              PROD_W = MAG_W + RCP_W;
    localparam longint unsigned SCALE  = longint'(1) << MAG_W;

    // floor(2^MAG_W / d) for every possible divisor
    logic [RCP_W-1:0] recip_tab [HIST_DEPTH + 1];

    for (genvar gi = 0; gi <= HIST_DEPTH; gi++)
    begin : g_recip
        if (gi == 0)
        begin : g_zero
            assign recip_tab[gi] = '0;
        end
        else
        begin : g_div
            localparam longint unsigned RECIP_VAL = SCALE / gi;
            assign recip_tab[gi] = RCP_W'(RECIP_VAL);
        end
    end

    logic               adv;
    logic               cmd_neg;
    sum_t               cmd_abs;

    logic               s0_valid_reg;
    logic [MAG_W-1:0]   s0_mag_reg;
    logic [RCP_W-1:0]   s0_rcp_reg;
    logic [DIV_W-1:0]   s0_div_reg;
    logic               s0_neg_reg;
    logic               s0_last_reg;

    logic               s1_valid_reg;
    logic [PROD_W-1:0]  s1_prod_reg;
    logic [MAG_W-1:0]   s1_mag_reg;
    logic [DIV_W-1:0]   s1_div_reg;
    logic               s1_neg_reg;
    logic               s1_last_reg;

    logic [SAMPLE_W-1:0] q0;

    logic               s2_valid_reg;
    logic [SAMPLE_W-1:0] s2_q0_reg;
    logic [QD_W-1:0]    s2_qd_reg;
    logic [MAG_W-1:0]   s2_mag_reg;
    logic [DIV_W-1:0]   s2_div_reg;
    logic               s2_neg_reg;
    logic               s2_last_reg;

    logic [QD_W-1:0]    rem;
    logic               bump;
    sample_t            avg_next;

    logic               out_valid_reg;
    sample_t            out_avg_reg;
    logic               out_last_reg;

    assign adv     = !out_valid_reg || res.ready;
    assign cmd_pop = adv && cmd_valid;

    assign cmd_neg = cmd.sum[SUM_W-1];
    assign cmd_abs = cmd_neg ? (~cmd.sum + SUM_W'(1)) : cmd.sum;

    assign q0 = s1_prod_reg[MAG_W +: SAMPLE_W];

    // estimate is exact or one short
    assign rem  = QD_W'(s2_mag_reg) - s2_qd_reg;
    assign bump = rem >= QD_W'(s2_div_reg);
    assign avg_next = s2_neg_reg ? (~s2_q0_reg + SAMPLE_W'(!bump))
                                 : (s2_q0_reg + SAMPLE_W'(bump));

    assign res.valid    = out_valid_reg;
    assign res.average  = out_avg_reg;
    assign res.last_out = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg  <= cmd_valid;
            s1_valid_reg  <= s0_valid_reg;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_mag_reg  <= cmd_abs[MAG_W-1:0];
            s0_rcp_reg  <= recip_tab[cmd.divisor];
            s0_div_reg  <= cmd.divisor;
            s0_neg_reg  <= cmd_neg;
            s0_last_reg <= cmd.last;

            s1_prod_reg <= PROD_W'(s0_mag_reg) * PROD_W'(s0_rcp_reg);
            s1_mag_reg  <= s0_mag_reg;
            s1_div_reg  <= s0_div_reg;
            s1_neg_reg  <= s0_neg_reg;
            s1_last_reg <= s0_last_reg;

            s2_q0_reg   <= q0;
            s2_qd_reg   <= QD_W'(q0) * QD_W'(s1_div_reg);
            s2_mag_reg  <= s1_mag_reg;
            s2_div_reg  <= s1_div_reg;
            s2_neg_reg  <= s1_neg_reg;
            s2_last_reg <= s1_last_reg;

            out_avg_reg  <= avg_next;
            out_last_reg <= s2_last_reg;
        end
    end

endmodule

`default_nettype wire

@@ design/centered_moving_average.sv @@
// ----------------------------------------------------------------------------
// centered_moving_average - windowed mean over a record of samples
// path: a result passes the command queue, then the s0, s1, s2 and output registers
// throughput: one sample per cycle while the command queue has room; after a
//   sample marked last_in the input holds ready low while the tail drains
// reset: control cleared, half width 1, sample history left unknown
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module centered_moving_average import cma_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    cma_sample_if.sink    smp,
    cma_result_if.source  res,
    cma_cfg_if.sink       cfg
);

    // front -> queue
    logic  push_valid;
    cmd_t  push_cmd;
    logic  fifo_full;

    // queue -> back
    logic  cmd_valid;
    cmd_t  cmd;
    logic  cmd_pop;

    // front end: keeps the last 2*MAX_HALF_WIDTH+1 samples and a running
    // window sum; each accepted sample yields at most one division job, and a
    // sample marked last_in starts the tail sequencer, which walks the window top
    // down one job per cycle while the queue has room, subtracting the oldest sample as the top shrinks
    cma_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .smp        (smp),
        .cfg        (cfg),
        .fifo_full  (fifo_full),
        .push_valid (push_valid),
        .push_cmd   (push_cmd)
    );

    // small queue so a stalled result side does not freeze the front
    // until it is actually full
    cma_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .full       (fifo_full),
        .pop_valid  (cmd_valid),
        .pop_cmd    (cmd),
        .pop        (cmd_pop)
    );

    // back end: sum / count truncated toward zero via reciprocal multiply,
    // one correction step, sign restore; output register holds the result
    // while the consumer stalls
    cma_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res       (res)
    );

endmodule

`default_nettype wire

@@ design/cma_checker.sv @@
// ----------------------------------------------------------------------------
// cma_checker
// port-level checks on the centered moving average, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cma_checker import cma_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     smp_valid,
    input  logic     smp_ready,
    input  logic     smp_last_in,
    input  logic     res_valid,
    input  logic     res_ready,
    input  sample_t  res_average,
    input  logic     res_last_out
);

    // a clock edge that saw reset is followed by no result offer
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !res_valid)
        else $error("result valid during reset");

    // a stalled result keeps its value
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_average)
                                    && $stable(res_last_out))
        else $error("stalled result changed");

    // end of record leaves at least one tail result to drain, unless a register write cuts it off
    a_tail_stall: assert property (@(posedge clk) disable iff (!rst_n)
        smp_valid && smp_ready && smp_last_in |=> !smp_ready)
        else $error("input ready right after end of record");

endmodule

bind centered_moving_average cma_checker u_cma_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .smp_valid    (smp.valid),
    .smp_ready    (smp.ready),
    .smp_last_in  (smp.last_in),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .res_average  (res.average),
    .res_last_out (res.last_out)
);

`default_nettype wire

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb - testbench of centered_moving_average
// feeds records of signed samples through the sample channel, predicts the
// clipped-window means in a local model and checks every result transaction
// in order, over several half width settings and idling patterns
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import cma_pkg::*;

    // run limits
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 30;
    localparam int PHASE_ITEMS   = 18;
    localparam int NUM_PHASES    = 8;
    localparam int LONG_RECORD   = 40;

    localparam sample_t SAMPLE_MAX = sample_t'(24'h7FFFFF);
    localparam sample_t SAMPLE_MIN = sample_t'(24'h800000);

    // one sample transaction as queued for the driver
    typedef struct {
        sample_t sample;
        logic    last;
    } record_item_t;

    // one smoothed value as it should leave the block
    typedef struct {
        sample_t average;
        logic    last;
    } mean_t;

    logic clk;
    logic rst_n;

    cma_sample_if smp_ch ();
    cma_result_if res_ch ();
    cma_cfg_if    cfg_ch ();

    centered_moving_average DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .smp   (smp_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    // stimulus and scoreboard storage
    record_item_t sample_queue[$];
    mean_t        mean_queue[$];
    record_item_t next_item;
    mean_t        oldest_mean;

    // local copy of the smoothing state
    sample_t          hist[HIST_DEPTH];
    int               seen_count;
    logic [CFG_W-1:0] half_width_reg;

    int queued_total;
    int accepted_total;
    int error_count;
    int cycle_count;

    // idling percentages of the current phase
    int src_idle_pct;
    int sink_stall_pct;

    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // local model of the filter
    // ------------------------------------------------------------------------

    // half width as the block uses it: zero acts as one, large values clip
    function automatic int effective_half(input logic [CFG_W-1:0] value);
        int h;
        h = int'(value);
        if (h == 0)
            h = 1;
        if (h > MAX_HALF_WIDTH)
            h = MAX_HALF_WIDTH;
        return h;
    endfunction

    // mean of the newest top+1 samples, window clipped at the record start
    function automatic void push_window_mean(input int top, input logic last);
        longint sum;
        longint quotient;
        mean_t  m;
        sum = 0;
        if (top > seen_count - 1)
            top = seen_count - 1;
        if (top > HIST_DEPTH - 1)
            top = HIST_DEPTH - 1;
        for (int k = 0; k <= top; k++)
            sum += longint'(hist[k]);
        // longint division truncates toward zero, as the block does
        quotient = sum / longint'(top + 1);
        m.average = sample_t'(quotient);
        m.last = last;
        mean_queue.push_back(m);
    endfunction

    // one accepted sample: shift it in and queue the means it completes
    function automatic void advance_window(input sample_t s, input logic last);
        int h;
        int pend;
        h = effective_half(half_width_reg);
        for (int k = HIST_DEPTH - 1; k > 0; k--)
            hist[k] = hist[k - 1];
        hist[0] = s;
        if (seen_count < HIST_DEPTH)
            seen_count++;
        // the sample h positions back now has its full right-hand side
        if (seen_count > h)
            push_window_mean(h + h, 1'b0);
        // end of record: drain the tail, oldest first, final one marked
        if (last)
        begin
            pend = (seen_count < h) ? seen_count : h;
            while (pend > 0)
            begin
                pend--;
                push_window_mean(pend + h, pend == 0);
            end
            seen_count = 0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic void add_item(input sample_t s, input logic last);
        record_item_t it;
        it.sample = s;
        it.last = last;
        sample_queue.push_back(it);
        queued_total++;
    endfunction

    // mostly full-range values, with extremes and tiny values mixed in so
    // that truncation of negative sums shows up
    function automatic sample_t pick_sample();
        case ($urandom_range(9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return sample_t'(int'($urandom_range(6)) - 3);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // a record of random samples; closed records end with last_in set
    function automatic void add_record(input int len, input bit closed);
        for (int i = 0; i < len; i++)
            add_item(pick_sample(), closed && (i == len - 1));
    endfunction

    // wait until every sample is taken and every mean has left, then let
    // samples of an open record that cause no result clear the pipeline
    task automatic drain();
        while (accepted_total != queued_total || mean_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write, only with the block idle; abandons any open record
    task automatic set_half_width(input logic [CFG_W-1:0] value);
        drain();
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.half_width <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        half_width_reg = value;
        seen_count = 0;
    endtask

    // ------------------------------------------------------------------------
    // driver: presents queued samples, holds each until its transaction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (smp_ch.valid && smp_ch.ready)
            begin
                advance_window(smp_ch.sample, smp_ch.last_in);
                accepted_total++;
            end
            // free to present the next sample, or to stay idle
            if (!smp_ch.valid || smp_ch.ready)
            begin
                if (sample_queue.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    next_item = sample_queue.pop_front();
                    smp_ch.valid <= 1'b1;
                    smp_ch.sample <= next_item.sample;
                    smp_ch.last_in <= next_item.last;
                end
                else
                begin
                    smp_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: random back-pressure, compares each result transaction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (mean_queue.size() == 0)
                begin
                    $error("unexpected result: average %0d, last_out %0b",
                           res_ch.average, res_ch.last_out);
                    error_count++;
                end
                else
                begin
                    oldest_mean = mean_queue.pop_front();
                    if (res_ch.average !== oldest_mean.average)
                    begin
                        $error("average: expected %0d, got %0d",
                               oldest_mean.average, res_ch.average);
                        error_count++;
                    end
                    if (res_ch.last_out !== oldest_mean.last)
                    begin
                        $error("last_out: expected %0b, got %0b",
                               oldest_mean.last, res_ch.last_out);
                        error_count++;
                    end
                end
            end
            res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [CFG_W-1:0] phase_half[NUM_PHASES];
        int               pushed;
        int               h;
        int               len;

        phase_half = '{4'd10, 4'd1, 4'd15, 4'd6, 4'd0, 4'd3, 4'd12, 4'd8};

        // every input known from time zero
        clk = 1'b0;
        rst_n = 1'b0;
        smp_ch.valid = 1'b0;
        smp_ch.sample = '0;
        smp_ch.last_in = 1'b0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.half_width = '0;

        for (int k = 0; k < HIST_DEPTH; k++)
            hist[k] = '0;
        seen_count = 0;
        half_width_reg = CFG_W'(HALF_WIDTH_RESET);
        queued_total = 0;
        accepted_total = 0;
        error_count = 0;
        cycle_count = 0;
        src_idle_pct = 0;
        sink_stall_pct = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: zero half width acts as one
        set_half_width(4'd0);
        add_item(SAMPLE_MAX, 1'b1);             // record of a single sample
        add_item(SAMPLE_MIN, 1'b0);             // two samples, most negative
        add_item(SAMPLE_MIN, 1'b1);
        add_item(sample_t'(-1), 1'b0);          // negative means round to zero
        add_item(sample_t'(0), 1'b0);
        add_item(sample_t'(-2), 1'b1);
        add_item(sample_t'(5), 1'b0);           // left open, dropped by the write
        add_item(sample_t'(7), 1'b0);

        // directed: oversized value clips to the widest window
        set_half_width(4'd15);
        for (int i = 0; i < 12; i++)
            add_item((i % 2 == 0) ? SAMPLE_MAX : SAMPLE_MIN, i == 11);
        add_item(sample_t'(3), 1'b0);           // short record under full width
        add_item(sample_t'(-4), 1'b0);
        add_item(sample_t'(100), 1'b1);

        // random phases, each with its own half width and idling pattern
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_half_width(phase_half[p]);
            case (p % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 46; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 46; end
                default: begin src_idle_pct = 25; sink_stall_pct = 25; end
            endcase
            h = effective_half(phase_half[p]);
            pushed = 0;
            // complete records only, short ones up to the window size
            while (pushed < PHASE_ITEMS)
            begin
                if ($urandom_range(2) == 0)
                    len = $urandom_range(LONG_RECORD, 1);
                else
                    len = $urandom_range(2 * h + 1, 1);
                add_record(len, 1'b1);
                pushed += len;
            end
            // sometimes a record stays open and the next write cuts it off
            if ($urandom_range(3) == 0)
                add_record($urandom_range(8, 1), 1'b0);
        end

        drain();
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ centered_moving_average.f @@
design/cma_pkg.sv
design/cma_if.sv
design/cma_front.sv
design/cma_cmd_fifo.sv
design/cma_back.sv
design/centered_moving_average.sv
design/cma_checker.sv
verif/tb.sv
